>>> rtl/core/vic_pkg.sv
package vic_pkg;

  // opcodes of an input word
  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_PINS  = 3'd2;
  localparam logic [2:0] OP_ACK   = 3'd3;
  localparam logic [2:0] OP_TIMER = 3'd4;
  localparam logic [2:0] OP_USART = 3'd5;

  // decoded register numbers
  localparam logic [3:0] REG_GPIP   = 4'd0;
  localparam logic [3:0] REG_AER    = 4'd1;
  localparam logic [3:0] REG_DDR    = 4'd2;
  localparam logic [3:0] REG_IER_HI = 4'd3;
  localparam logic [3:0] REG_IER_LO = 4'd4;
  localparam logic [3:0] REG_IPR_HI = 4'd5;
  localparam logic [3:0] REG_IPR_LO = 4'd6;
  localparam logic [3:0] REG_ISR_HI = 4'd7;
  localparam logic [3:0] REG_ISR_LO = 4'd8;
  localparam logic [3:0] REG_IMR_HI = 4'd9;
  localparam logic [3:0] REG_IMR_LO = 4'd10;
  localparam logic [3:0] REG_IVR    = 4'd11;

  localparam logic [15:0] KEEP_REQ_MASK    = 16'h3f30;
  localparam logic [15:0] USART_CLEAR_MASK = 16'he1ff;
  localparam logic [7:0]  IVR_WRITE_MASK   = 8'hf8;
  localparam logic [7:0]  IVR_BASE_MASK    = 8'hf0;
  localparam logic [7:0]  INVERT_RESET     = 8'hff;

  localparam logic [3:0] CH_RX_ERR  = 4'd11;
  localparam logic [3:0] CH_RX_FULL = 4'd12;
  localparam logic [3:0] CH_TX_ERR  = 4'd9;
  localparam logic [3:0] CH_TX_MT   = 4'd10;

  // timer A..D channel bits
  localparam logic [15:0] TIMER_CHANNEL [4] = '{
    16'h2000, 16'h0100, 16'h0020, 16'h0010
  };

  // channel-side state that the evaluate pass reads and rewrites
  typedef struct packed {
    logic [15:0] enable;
    logic [15:0] pending;
    logic [15:0] in_service;
    logic [15:0] mask;
    logic [15:0] req_now;
    logic [15:0] req_before;
  } irq_state_t;

  // {found, index} of the highest set bit
  function automatic logic [4:0] top_bit(input logic [15:0] v);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) r = {1'b1, 4'(i)};
    end
    return r;
  endfunction

endpackage

>>> rtl/core/vectored_interrupt_controller_unit.sv
// Vectored interrupt controller with GPIO pin inputs, 16 channels.
//
// Input channel (in_valid/in_ready) carries one word: opcode plus the
// fields it needs (bus read/write of a decoded register, pin change,
// acknowledge, timer event, usart status levels). Output channel
// (out_valid/out_ready) returns one word per input word: read_data,
// vector, vector_valid and the irq_line level after that word.
//
// The output word is registered. Throughput: one word per cycle while the
// receiver takes every word; the whole update is a single combinational pass
// (priority encode, edge detect, irq compare) into the state and the
// output register.
//
// When the receiver stalls, the output word holds and in_ready drops
// until it is taken; a word is accepted in the same cycle the old one
// leaves.
//
// Reset (rst, synchronous) clears all controller state and the output valid;
// the pin invert mask returns to 0xff. cfg_write_en writes the invert mask at
// once; the user must do so only while the block is idle, it is not enforced.
module vectored_interrupt_controller_unit
  import vic_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [7:0] cfg_write_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] opcode,
  input  logic [3:0] reg_index,
  input  logic [7:0] write_data,
  input  logic [7:0] pin_levels,
  input  logic [1:0] timer_id,
  input  logic [3:0] usart_flags,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic [7:0] vector,
  output logic       vector_valid,
  output logic       irq_line
);

  // architectural state
  logic [7:0] pin_invert_mask;
  logic [7:0] pin_input, pin_input_next;
  logic [7:0] output_latch, output_latch_next;
  logic [7:0] edge_select, edge_select_next;
  logic [7:0] direction, direction_next;
  logic [7:0] vector_base, vector_base_next;
  logic [7:0] last_vector, last_vector_next;
  logic       irq_level, irq_level_next;
  irq_state_t irq_st, irq_st_next;

  // result word before the output register
  logic [7:0] rd_next, vec_next;
  logic       valid_next;

  logic       accept;

  // working values of the combinational pass
  irq_state_t st;
  logic       do_eval;
  logic [7:0] lv;
  logic [15:0] req;
  logic [15:0] act;
  logic [4:0]  top_pend, top_act;
  logic [15:0] ack_bit;
  logic [15:0] usart_req;
  logic [15:0] hi_byte;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    st                = irq_st;
    pin_input_next    = pin_input;
    output_latch_next = output_latch;
    edge_select_next  = edge_select;
    direction_next    = direction;
    vector_base_next  = vector_base;
    last_vector_next  = last_vector;
    irq_level_next    = irq_level;
    do_eval           = 1'b0;
    rd_next           = 8'd0;
    vec_next          = 8'd0;
    valid_next        = 1'b0;
    hi_byte           = {write_data, 8'h00};
    top_pend          = top_bit(irq_st.pending & irq_st.mask);
    ack_bit           = 16'd1 << top_pend[3:0];
    usart_req         = irq_st.req_now & USART_CLEAR_MASK;

    if (usart_flags[0]) usart_req[CH_RX_ERR] = 1'b1;
    else if (usart_flags[1]) usart_req[CH_RX_FULL] = 1'b1;
    if (usart_flags[2]) usart_req[CH_TX_ERR] = 1'b1;
    else if (usart_flags[3]) usart_req[CH_TX_MT] = 1'b1;

    case (opcode)
      OP_READ: begin
        unique case (reg_index)
          REG_GPIP:   rd_next = (output_latch & direction) |
                                ((pin_input ^ pin_invert_mask) & ~direction);
          REG_AER:    rd_next = edge_select;
          REG_DDR:    rd_next = direction;
          REG_IER_HI: rd_next = irq_st.enable[15:8];
          REG_IER_LO: rd_next = irq_st.enable[7:0];
          REG_IPR_HI: rd_next = irq_st.pending[15:8];
          REG_IPR_LO: rd_next = irq_st.pending[7:0];
          REG_ISR_HI: rd_next = irq_st.in_service[15:8];
          REG_ISR_LO: rd_next = irq_st.in_service[7:0];
          REG_IMR_HI: rd_next = irq_st.mask[15:8];
          REG_IMR_LO: rd_next = irq_st.mask[7:0];
          REG_IVR:    rd_next = last_vector;
          default:    rd_next = 8'd0;
        endcase
      end
      OP_WRITE: begin
        unique case (reg_index)
          REG_GPIP: output_latch_next = write_data;
          REG_AER: begin
            edge_select_next = write_data;
            do_eval = 1'b1;
          end
          REG_DDR: direction_next = write_data;
          REG_IER_HI: begin
            st.enable[15:8] = write_data;
            do_eval = 1'b1;
          end
          REG_IER_LO: begin
            st.enable[7:0] = write_data;
            do_eval = 1'b1;
          end
          REG_IPR_HI: begin
            st.pending = irq_st.pending & (hi_byte | 16'h00ff);
            do_eval = 1'b1;
          end
          REG_IPR_LO: begin
            st.pending = irq_st.pending & {8'hff, write_data};
            do_eval = 1'b1;
          end
          REG_ISR_HI: begin
            st.in_service = irq_st.in_service & (hi_byte | 16'h00ff);
            do_eval = 1'b1;
          end
          REG_ISR_LO: begin
            st.in_service = irq_st.in_service & {8'hff, write_data};
            do_eval = 1'b1;
          end
          REG_IMR_HI: begin
            st.mask[15:8] = write_data;
            do_eval = 1'b1;
          end
          REG_IMR_LO: begin
            st.mask[7:0] = write_data;
            do_eval = 1'b1;
          end
          REG_IVR: vector_base_next = write_data & IVR_WRITE_MASK;
          default: ;
        endcase
      end
      OP_PINS: begin
        if (pin_levels != pin_input) begin
          pin_input_next = pin_levels;
          do_eval = 1'b1;
        end
      end
      OP_ACK: begin
        if (top_pend[4]) begin
          st.pending = irq_st.pending & ~ack_bit;
          if (vector_base[3]) st.in_service = irq_st.in_service | ack_bit;
          last_vector_next = (vector_base & IVR_BASE_MASK) | {4'd0, top_pend[3:0]};
          vec_next   = last_vector_next;
          valid_next = 1'b1;
          do_eval    = 1'b1;
        end
      end
      OP_TIMER: begin
        if ((irq_st.enable & TIMER_CHANNEL[timer_id]) != 16'd0) begin
          st.pending = irq_st.pending | TIMER_CHANNEL[timer_id];
          do_eval = 1'b1;
        end
      end
      OP_USART: begin
        if (usart_req != irq_st.req_now) begin
          st.req_now = usart_req;
          do_eval = 1'b1;
        end
      end
      default: ;
    endcase

    // evaluate pass: request edges into pending, then the irq level
    lv  = pin_input_next ^ pin_invert_mask ^ ~edge_select_next;
    req = (st.req_now & KEEP_REQ_MASK) |
          {lv[7:6], 6'd0, lv[5:4], 2'd0, lv[3:0]};
    act = ((st.pending | ((req ^ st.req_before) & req)) & st.enable) & st.mask;
    top_act = top_bit(act);

    irq_st_next = st;
    if (do_eval) begin
      irq_st_next.req_now    = req;
      irq_st_next.pending    = (st.pending | ((req ^ st.req_before) & req)) & st.enable;
      irq_st_next.req_before = req;
      if (vector_base_next[3]) begin
        // software end-of-interrupt: must outrank everything in service
        irq_level_next = top_act[4] && ((16'd1 << top_act[3:0]) > st.in_service);
      end else begin
        irq_level_next = act != 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_invert_mask <= INVERT_RESET;
    end else if (cfg_write_en) begin
      pin_invert_mask <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_input    <= 8'd0;
      output_latch <= 8'd0;
      edge_select  <= 8'd0;
      direction    <= 8'd0;
      vector_base  <= 8'd0;
      last_vector  <= 8'd0;
      irq_level    <= 1'b0;
      irq_st       <= '0;
    end else if (accept) begin
      pin_input    <= pin_input_next;
      output_latch <= output_latch_next;
      edge_select  <= edge_select_next;
      direction    <= direction_next;
      vector_base  <= vector_base_next;
      last_vector  <= last_vector_next;
      irq_level    <= irq_level_next;
      irq_st       <= irq_st_next;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data    <= rd_next;
      vector       <= vec_next;
      vector_valid <= valid_next;
      irq_line     <= irq_level_next;
    end
  end

endmodule

>>> rtl/core/vic_checker.sv
module vic_checker
  import vic_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_data,
  input logic [7:0] vector,
  input logic       vector_valid,
  input logic       irq_line
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(vector) &&
      $stable(vector_valid) && $stable(irq_line))
    else $error("output word changed while stalled");

  // every accepted word yields an output word next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("no output word after accept");

  // empty output register never blocks the input side
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // vector only on a successful acknowledge, never alongside read data
  a_vec_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !vector_valid |-> vector == 8'd0)
    else $error("vector without vector_valid");

  a_rd_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid && vector_valid |-> read_data == 8'd0)
    else $error("read data on an acknowledge");

endmodule

bind vectored_interrupt_controller_unit vic_checker u_vic_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .read_data    (read_data),
  .vector       (vector),
  .vector_valid (vector_valid),
  .irq_line     (irq_line)
);

>>> tb/testbench.sv
module testbench;
  import vic_pkg::*;

  // opcodes and register numbers the block decodes to nothing
  localparam logic [2:0] OP_SPARE_LO  = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;
  localparam logic [3:0] REG_SPARE_LO = 4'd12;
  localparam logic [3:0] REG_SPARE_HI = 4'd15;

  // usart status flag bits
  localparam int UF_RX_ERR   = 0;
  localparam int UF_RX_FULL  = 1;
  localparam int UF_TX_ERR   = 2;
  localparam int UF_TX_EMPTY = 3;

  // ivr bit that selects software end-of-interrupt
  localparam int IVR_SEI_BIT = 3;

  localparam int QUIET_LIMIT  = 500;   // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 4;     // output word is registered, keep some margin
  localparam int PRINT_LIMIT  = 40;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] rsel;
    logic [7:0] data;
    logic [7:0] pins;
    logic [1:0] tid;
    logic [3:0] uflags;
  } bus_cmd_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic [7:0] vec;
    logic       vld;
    logic       irq;
  } irq_reply_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write_en = 1'b0;
  logic [7:0] cfg_write_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] opcode = OP_READ;
  logic [3:0] reg_index = REG_GPIP;
  logic [7:0] write_data = 8'h00;
  logic [7:0] pin_levels = 8'h00;
  logic [1:0] timer_id = 2'd0;
  logic [3:0] usart_flags = 4'd0;
  logic       out_valid;
  logic       out_ready = 1'b1;
  logic [7:0] read_data;
  logic [7:0] vector;
  logic       vector_valid;
  logic       irq_line;

  always #10 clk = ~clk;

  vectored_interrupt_controller_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .reg_index     (reg_index),
    .write_data    (write_data),
    .pin_levels    (pin_levels),
    .timer_id      (timer_id),
    .usart_flags   (usart_flags),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_data     (read_data),
    .vector        (vector),
    .vector_valid  (vector_valid),
    .irq_line      (irq_line)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the controller. Updated once per accepted input word, in
  // the order the block sees them; the invert mask is only changed while idle.
  // ---------------------------------------------------------------------------
  logic [7:0]  sh_invert;
  logic [7:0]  sh_pins;
  logic [7:0]  sh_latch;
  logic [7:0]  sh_edges;
  logic [7:0]  sh_dir;
  logic [7:0]  sh_vbase;
  logic [7:0]  sh_lastvec;
  logic [15:0] sh_ier;
  logic [15:0] sh_ipr;
  logic [15:0] sh_isr;
  logic [15:0] sh_imr;
  logic [15:0] sh_req;
  logic [15:0] sh_req_prev;
  logic        sh_irq;

  bus_cmd_t   cmd_backlog[$];    // words still to be sent
  irq_reply_t replies_due[$];    // predicted replies, oldest first
  int         mismatches = 0;

  function automatic void clear_shadow();
    sh_invert   = INVERT_RESET;
    sh_pins     = '0;
    sh_latch    = '0;
    sh_edges    = '0;
    sh_dir      = '0;
    sh_vbase    = '0;
    sh_lastvec  = '0;
    sh_ier      = '0;
    sh_ipr      = '0;
    sh_isr      = '0;
    sh_imr      = '0;
    sh_req      = '0;
    sh_req_prev = '0;
    sh_irq      = 1'b0;
  endfunction

  // highest set channel, -1 when none
  function automatic int top_channel(input logic [15:0] v);
    int hit;
    hit = -1;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) hit = i;
    end
    return hit;
  endfunction

  // Edge detect on the request lines, latch into pending, recompute irq.
  function automatic void refresh_irq();
    logic [7:0]  lv;
    logic [15:0] act;
    int          t;
    // edge_select 0 means a falling level counts, so fold it in by xor
    lv = (sh_pins ^ sh_invert) ^ ~sh_edges;
    // pins 0-3 -> ch 0-3, pins 4-5 -> ch 6-7, pins 6-7 -> ch 14-15
    sh_req = (sh_req & KEEP_REQ_MASK) | {lv[7:6], 6'b0, lv[5:4], 2'b0, lv[3:0]};
    sh_ipr = (sh_ipr | ((sh_req ^ sh_req_prev) & sh_req)) & sh_ier;
    sh_req_prev = sh_req;
    act = sh_ipr & sh_imr;
    t = top_channel(act);
    if (!sh_vbase[IVR_SEI_BIT]) begin
      sh_irq = (act != 16'h0);
    end else if (t < 0) begin
      sh_irq = 1'b0;
    end else begin
      // must outrank everything in service
      sh_irq = ((32'd1 << t) > {16'h0, sh_isr});
    end
  endfunction

  function automatic logic [7:0] read_reg(input logic [3:0] r);
    case (r)
      REG_GPIP:   return (sh_latch & sh_dir) | ((sh_pins ^ sh_invert) & ~sh_dir);
      REG_AER:    return sh_edges;
      REG_DDR:    return sh_dir;
      REG_IER_HI: return sh_ier[15:8];
      REG_IER_LO: return sh_ier[7:0];
      REG_IPR_HI: return sh_ipr[15:8];
      REG_IPR_LO: return sh_ipr[7:0];
      REG_ISR_HI: return sh_isr[15:8];
      REG_ISR_LO: return sh_isr[7:0];
      REG_IMR_HI: return sh_imr[15:8];
      REG_IMR_LO: return sh_imr[7:0];
      REG_IVR:    return sh_lastvec;
      default:    return 8'h00;
    endcase
  endfunction

  function automatic void write_reg(input logic [3:0] r, input logic [7:0] d);
    case (r)
      REG_GPIP: sh_latch = d;
      REG_AER: begin
        sh_edges = d;
        refresh_irq();
      end
      REG_DDR: sh_dir = d;
      REG_IER_HI: begin
        sh_ier[15:8] = d;
        refresh_irq();
      end
      REG_IER_LO: begin
        sh_ier[7:0] = d;
        refresh_irq();
      end
      // pending and in-service writes can only clear
      REG_IPR_HI: begin
        sh_ipr[15:8] = sh_ipr[15:8] & d;
        refresh_irq();
      end
      REG_IPR_LO: begin
        sh_ipr[7:0] = sh_ipr[7:0] & d;
        refresh_irq();
      end
      REG_ISR_HI: begin
        sh_isr[15:8] = sh_isr[15:8] & d;
        refresh_irq();
      end
      REG_ISR_LO: begin
        sh_isr[7:0] = sh_isr[7:0] & d;
        refresh_irq();
      end
      REG_IMR_HI: begin
        sh_imr[15:8] = d;
        refresh_irq();
      end
      REG_IMR_LO: begin
        sh_imr[7:0] = d;
        refresh_irq();
      end
      REG_IVR: sh_vbase = d & IVR_WRITE_MASK;   // no irq refresh here
      default: ;
    endcase
  endfunction

  // One input word through the shadow controller; returns its reply.
  function automatic irq_reply_t controller_step(input bus_cmd_t c);
    irq_reply_t  rep;
    logic [15:0] hit_bit;
    logic [15:0] nreq;
    int          t;
    rep = '0;
    case (c.op)
      OP_READ:  rep.rdata = read_reg(c.rsel);
      OP_WRITE: write_reg(c.rsel, c.data);
      OP_PINS: begin
        if (c.pins != sh_pins) begin
          sh_pins = c.pins;
          refresh_irq();
        end
      end
      OP_ACK: begin
        t = top_channel(sh_ipr & sh_imr);
        if (t >= 0) begin
          hit_bit = 16'h1 << t;
          sh_ipr = sh_ipr & ~hit_bit;
          if (sh_vbase[IVR_SEI_BIT]) sh_isr = sh_isr | hit_bit;
          sh_lastvec = (sh_vbase & IVR_BASE_MASK) | 8'(t);
          refresh_irq();
          rep.vec = sh_lastvec;
          rep.vld = 1'b1;
        end
      end
      OP_TIMER: begin
        if ((sh_ier & TIMER_CHANNEL[c.tid]) != 16'h0) begin
          sh_ipr = sh_ipr | TIMER_CHANNEL[c.tid];
          refresh_irq();
        end
      end
      OP_USART: begin
        // rx error wins over rx full, tx error over tx empty
        nreq = sh_req & USART_CLEAR_MASK;
        if (c.uflags[UF_RX_ERR]) nreq[CH_RX_ERR] = 1'b1;
        else if (c.uflags[UF_RX_FULL]) nreq[CH_RX_FULL] = 1'b1;
        if (c.uflags[UF_TX_ERR]) nreq[CH_TX_ERR] = 1'b1;
        else if (c.uflags[UF_TX_EMPTY]) nreq[CH_TX_MT] = 1'b1;
        if (nreq != sh_req) begin
          sh_req = nreq;
          refresh_irq();
        end
      end
      default: ;
    endcase
    rep.irq = sh_irq;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  logic [7:0] last_pins_gen = 8'h00;

  function automatic bus_cmd_t pack_cmd(input logic [2:0] op, input logic [3:0] rsel,
                                        input logic [7:0] data, input logic [7:0] pins,
                                        input logic [1:0] tid, input logic [3:0] uflags);
    bus_cmd_t c;
    c.op = op;
    c.rsel = rsel;
    c.data = data;
    c.pins = pins;
    c.tid = tid;
    c.uflags = uflags;
    return c;
  endfunction

  // mostly ones: keeps enables/masks open and clears only a few bits
  function automatic logic [7:0] dense_byte();
    return 8'($urandom | $urandom);
  endfunction

  function automatic bus_cmd_t random_cmd();
    bus_cmd_t c;
    int       roll;
    c.rsel = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(REG_SPARE_LO, REG_SPARE_HI))
                                        : 4'($urandom_range(REG_GPIP, REG_IVR));
    c.data = 8'($urandom);
    c.pins = 8'($urandom);
    c.tid = 2'($urandom);
    c.uflags = 4'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 14) begin
      c.op = OP_READ;
    end else if (roll < 44) begin
      c.op = OP_WRITE;
      if (c.rsel >= REG_IER_HI && c.rsel <= REG_IMR_LO && $urandom_range(0, 1) == 1)
        c.data = dense_byte();
    end else if (roll < 58) begin
      c.op = OP_PINS;
      // repeat levels, flip one pin, or jump anywhere
      case ($urandom_range(0, 3))
        0: c.pins = last_pins_gen;
        1: c.pins = last_pins_gen ^ (8'h01 << $urandom_range(0, 7));
        default: ;
      endcase
      last_pins_gen = c.pins;
    end else if (roll < 74) begin
      c.op = OP_ACK;
    end else if (roll < 84) begin
      c.op = OP_TIMER;
    end else if (roll < 95) begin
      c.op = OP_USART;
    end else begin
      c.op = ($urandom_range(0, 1) == 1) ? OP_SPARE_LO : OP_SPARE_HI;
    end
    return c;
  endfunction

  // A well-formed round: open channels, raise events, acknowledge, and sometimes end service.
  task automatic queue_service_round();
    bus_cmd_t e;
    cmd_backlog.push_back(pack_cmd(OP_WRITE, REG_IER_HI, dense_byte(), 0, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_WRITE, REG_IER_LO, dense_byte(), 0, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_WRITE, REG_IMR_HI, dense_byte(), 0, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_WRITE, REG_IMR_LO, dense_byte(), 0, 0, 0));
    repeat ($urandom_range(2, 5)) begin
      e = random_cmd();
      case ($urandom_range(0, 2))
        0: e.op = OP_PINS;
        1: e.op = OP_TIMER;
        default: e.op = OP_USART;
      endcase
      cmd_backlog.push_back(e);
    end
    repeat ($urandom_range(1, 3)) begin
      cmd_backlog.push_back(pack_cmd(OP_ACK, 0, 0, 0, 0, 0));
    end
    if ($urandom_range(0, 1) == 1) begin
      cmd_backlog.push_back(pack_cmd(OP_WRITE, REG_ISR_HI, 8'($urandom), 0, 0, 0));
      cmd_backlog.push_back(pack_cmd(OP_WRITE, REG_ISR_LO, 8'($urandom), 0, 0, 0));
    end
  endtask

  task automatic add_random(input int count);
    int added;
    int size_was;
    added = 0;
    while (added < count) begin
      size_was = cmd_backlog.size();
      if ($urandom_range(0, 4) == 0) queue_service_round();
      else cmd_backlog.push_back(random_cmd());
      added += cmd_backlog.size() - size_was;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: sends words from the backlog, with random bursts of idle cycles.
  // The shadow controller advances at the edge where a word is accepted.
  // ---------------------------------------------------------------------------
  int       gap_one_in = 0;   // chance of a burst per free slot, 0 = never
  int       send_gap = 0;
  int       stall_left = 0;
  bus_cmd_t next_cmd;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        replies_due.push_back(controller_step(bus_cmd_t'({opcode, reg_index, write_data,
                                                          pin_levels, timer_id, usart_flags})));
      if (!in_valid || in_ready) begin
        if (send_gap == 0 && gap_one_in != 0 && $urandom_range(1, gap_one_in) == 1)
          send_gap = $urandom_range(1, 9);
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          next_cmd = cmd_backlog.pop_front();
          opcode <= next_cmd.op;
          reg_index <= next_cmd.rsel;
          write_data <= next_cmd.data;
          pin_levels <= next_cmd.pins;
          timer_id <= next_cmd.tid;
          usart_flags <= next_cmd.uflags;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each reply word against the oldest prediction, and
  // throttles out_ready with random stall bursts.
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_LIMIT)
      $display("mismatch %s: got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  irq_reply_t want_rep;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          flag_mismatch("reply with none due, read_data", read_data, 0);
        end else begin
          want_rep = replies_due.pop_front();
          if (read_data !== want_rep.rdata)
            flag_mismatch("read_data", read_data, want_rep.rdata);
          if (vector !== want_rep.vec)
            flag_mismatch("vector", vector, want_rep.vec);
          if (vector_valid !== want_rep.vld)
            flag_mismatch("vector_valid", vector_valid, want_rep.vld);
          if (irq_line !== want_rep.irq)
            flag_mismatch("irq_line", irq_line, want_rep.irq);
        end
      end
      if (stall_left == 0 && gap_one_in != 0 && $urandom_range(1, gap_one_in) == 1)
        stall_left = $urandom_range(1, 9);
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any handshake means the block hung.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing: directed words, then random phases under different invert
  // masks. The mask is only rewritten once the block has fully drained.
  // ---------------------------------------------------------------------------

  // sampled at the falling edge so all driver updates have landed
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || replies_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input logic [7:0] invert, input int one_in, input int count);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= invert;
    sh_invert = invert;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    gap_one_in = one_in;
    add_random(count);
    wait_drained();
  endtask

  initial begin
    clear_shadow();
    gap_one_in = 5;

    // reset state readback, then open every channel
    cmd_backlog.push_back(pack_cmd(OP_READ, REG_GPIP, 0, 0, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_WRITE, REG_IER_HI, 8'hff, 0, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_WRITE, REG_IER_LO, 8'hff, 0, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_WRITE, REG_IMR_HI, 8'hff, 0, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_WRITE, REG_IMR_LO, 8'hff, 0, 0, 0));
    // pin edges, and a pin change to the same levels
    cmd_backlog.push_back(pack_cmd(OP_PINS, 0, 0, 8'hff, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_PINS, 0, 0, 8'hff, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_PINS, 0, 0, 8'h00, 0, 0));
    // timers A and D, usart all flags, unchanged usart levels, usart clear
    cmd_backlog.push_back(pack_cmd(OP_TIMER, 0, 0, 0, 2'd0, 0));
    cmd_backlog.push_back(pack_cmd(OP_TIMER, 0, 0, 0, 2'd3, 0));
    cmd_backlog.push_back(pack_cmd(OP_USART, 0, 0, 0, 0, 4'hf));
    cmd_backlog.push_back(pack_cmd(OP_USART, 0, 0, 0, 0, 4'hf));
    cmd_backlog.push_back(pack_cmd(OP_USART, 0, 0, 0, 0, 4'h0));
    cmd_backlog.push_back(pack_cmd(OP_ACK, 0, 0, 0, 0, 0));
    // software end-of-interrupt mode: acks now set in-service
    cmd_backlog.push_back(pack_cmd(OP_WRITE, REG_IVR, 8'hff, 0, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_ACK, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_ACK, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_READ, REG_ISR_HI, 0, 0, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_READ, REG_IVR, 0, 0, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_WRITE, REG_ISR_HI, 8'h00, 0, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_WRITE, REG_IPR_LO, 8'h00, 0, 0, 0));
    // gpio readback mixes latch and pins by direction
    cmd_backlog.push_back(pack_cmd(OP_WRITE, REG_DDR, 8'hf0, 0, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_WRITE, REG_GPIP, 8'ha5, 0, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_READ, REG_GPIP, 0, 0, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_WRITE, REG_AER, 8'hff, 0, 0, 0));
    // unknown registers and opcodes
    cmd_backlog.push_back(pack_cmd(OP_READ, REG_SPARE_HI, 0, 0, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_WRITE, REG_SPARE_LO, 8'hff, 0, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_SPARE_HI, 0, 0, 0, 0, 0));
    // timer on a disabled channel, then ack with nothing to hand out
    cmd_backlog.push_back(pack_cmd(OP_WRITE, REG_IER_HI, 8'h00, 0, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_TIMER, 0, 0, 0, 2'd0, 0));
    cmd_backlog.push_back(pack_cmd(OP_WRITE, REG_IMR_LO, 8'h00, 0, 0, 0));
    cmd_backlog.push_back(pack_cmd(OP_ACK, 0, 0, 0, 0, 0));
    add_random(140);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    run_phase(8'h00, 3, 190);
    run_phase(8'($urandom), 0, 190);     // a stretch with no idling
    run_phase(8'h5a, 2, 190);
    run_phase(8'hff, 0, 190);            // tail runs at full rate

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/vic_pkg.sv
rtl/core/vectored_interrupt_controller_unit.sv
rtl/core/vic_checker.sv
tb/testbench.sv
